FILE: design/next_fit_page_allocator_unit_macros.svh
// Assertion helpers used by the checker of the allocator.
`ifndef NEXT_FIT_PAGE_ALLOCATOR_UNIT_MACROS_SVH
`define NEXT_FIT_PAGE_ALLOCATOR_UNIT_MACROS_SVH

// Clocked check, off while reset is high.
`define NPA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check, also active during reset.
`define NPA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: design/npa_pkg.sv
package npa_pkg;

   localparam int TABLE_PAGES = 1024;
   localparam int WORD_BITS   = 32;
   localparam int WORDS       = TABLE_PAGES / WORD_BITS;
   localparam int PAGE_W      = $clog2(TABLE_PAGES);
   localparam int BIT_W       = $clog2(WORD_BITS);
   localparam int ROW_W       = PAGE_W - BIT_W;
   localparam int BOUND_W     = PAGE_W + 1;

   localparam int OP_W   = 2;
   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 16;

   localparam logic [OP_W-1:0] OP_ALLOCATE      = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE          = 2'd1;
   localparam logic [OP_W-1:0] OP_MARK_USABLE   = 2'd2;
   localparam logic [OP_W-1:0] OP_MARK_RESERVED = 2'd3;

   localparam logic [1:0] REG_RANGE_LOW  = 2'd0;
   localparam logic [1:0] REG_RANGE_HIGH = 2'd1;
   localparam logic [1:0] REG_PAGE_COUNT = 2'd2;

   localparam logic [PAGE_W-1:0]  RANGE_LOW_RESET  = 10'd256;
   localparam logic [BOUND_W-1:0] RANGE_HIGH_RESET = 11'd960;
   localparam logic [BOUND_W-1:0] PAGE_COUNT_RESET = 11'd1024;

   typedef struct packed {
      logic load;
      logic scan_init;
      logic scan_run;
      logic rmw_read;
      logic rmw_write;
      logic empty_fail;
   } npa_cmd_type;

   typedef struct packed {
      logic ring_empty;
      logic scan_hit;
      logic scan_done;
   } npa_status_type;

endpackage

FILE: design/npa_ctrl.sv
module npa_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [npa_pkg::OP_W-1:0]   req_op,
   input  logic                       out_free,
   input  npa_pkg::npa_status_type    status,
   output logic                       req_ready,
   output logic                       push,
   output npa_pkg::npa_cmd_type       cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RD   = 3'd1;
   localparam logic [2:0] ST_WR   = 3'd2;
   localparam logic [2:0] ST_SCAN = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      push      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_op == npa_pkg::OP_ALLOCATE) begin
                  if (status.ring_empty) begin
                     cmd.empty_fail = 1'b1;
                     state_in       = ST_DONE;
                  end else begin
                     cmd.scan_init = 1'b1;
                     state_in      = ST_SCAN;
                  end
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         ST_RD: begin
            cmd.rmw_read = 1'b1;
            state_in     = ST_WR;
         end
         ST_WR: begin
            cmd.rmw_write = 1'b1;
            state_in      = ST_DONE;
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (status.scan_hit || status.scan_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               push     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: design/npa_dpath.sv
module npa_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  npa_pkg::npa_cmd_type          cmd,
   output npa_pkg::npa_status_type       status,
   input  logic [npa_pkg::OP_W-1:0]      req_op,
   input  logic [npa_pkg::PAGE_W-1:0]    req_page,
   input  logic [npa_pkg::PAGE_W-1:0]    range_low,
   input  logic [npa_pkg::BOUND_W-1:0]   range_high,
   input  logic [npa_pkg::BOUND_W-1:0]   page_count,
   output logic [npa_pkg::PAGE_W-1:0]    granted_page,
   output logic                          found
);

   localparam int PW = npa_pkg::PAGE_W;
   localparam int BW = npa_pkg::BOUND_W;
   localparam int RW = npa_pkg::ROW_W;
   localparam int IW = npa_pkg::BIT_W;
   localparam int WB = npa_pkg::WORD_BITS;

   function automatic logic [IW-1:0] low_bit(input logic [WB-1:0] v);
      logic [IW-1:0] r;
      r = '0;
      for (int i = WB - 1; i >= 0; i--) begin
         if (v[i]) r = IW'(i);
      end
      return r;
   endfunction

   function automatic logic [WB-1:0] below_mask(input logic [RW-1:0] row,
                                                input logic [BW-1:0] bound);
      logic [RW:0] brow;
      brow = bound[BW-1:IW];
      if ({1'b0, row} < brow) return '1;
      else if ({1'b0, row} == brow) return ~({WB{1'b1}} << bound[IW-1:0]);
      else return '0;
   endfunction

   logic [WB-1:0] usable_mem [npa_pkg::WORDS];
   logic [WB-1:0] alloc_mem  [npa_pkg::WORDS];
   logic [npa_pkg::WORDS-1:0] row_ok_ff;

   logic [WB-1:0] usable_rd_ff;
   logic [WB-1:0] alloc_rd_ff;
   logic          row_rd_ok_ff;

   logic [npa_pkg::OP_W-1:0] op_ff;
   logic [PW-1:0] page_ff;
   logic [PW-1:0] scan_start_ff;
   logic [PW-1:0] start_ff;
   logic [RW-1:0] issue_row_ff, issue_row_in;
   logic [RW-1:0] end_row_ff, end_row_in;
   logic          pass_ff, pass_in;
   logic          issuing_ff, issuing_in;
   logic          ev_valid_ff, ev_valid_in;
   logic [RW-1:0] ev_row_ff;
   logic          ev_pass_ff;
   logic [PW-1:0] res_page_ff;
   logic          res_found_ff;

   logic [BW-1:0] hi_eff;
   logic [BW-1:0] hi_m1;
   logic [PW-1:0] start_eff;
   logic [PW-1:0] start_m1;
   logic [RW-1:0] rd_addr;
   logic [WB-1:0] use_w, alc_w;
   logic [PW-1:0] a_bound;
   logic [BW-1:0] b_bound;
   logic [WB-1:0] lo_mask, cand;
   logic [IW-1:0] hit_bit;
   logic [PW-1:0] hit_page;
   logic          scan_hit;
   logic          wr_en;
   logic [RW-1:0] wr_addr;
   logic [WB-1:0] wr_usable, wr_alloc, sel;

   always_comb begin
      hi_eff = (range_high > BW'(npa_pkg::TABLE_PAGES)) ? BW'(npa_pkg::TABLE_PAGES)
                                                        : range_high;
      hi_m1  = hi_eff - BW'(1);
      if ({1'b0, scan_start_ff} >= {1'b0, range_low} && {1'b0, scan_start_ff} < hi_eff) begin
         start_eff = scan_start_ff;
      end else begin
         start_eff = range_low;
      end
      start_m1 = start_ff - PW'(1);
   end

   always_comb begin
      issue_row_in = issue_row_ff;
      end_row_in   = end_row_ff;
      pass_in      = pass_ff;
      issuing_in   = issuing_ff;
      if (cmd.scan_init) begin
         issue_row_in = start_eff[PW-1:IW];
         end_row_in   = hi_m1[PW-1:IW];
         pass_in      = 1'b0;
         issuing_in   = 1'b1;
      end else if (!cmd.scan_run) begin
         issuing_in = 1'b0;
      end else if (issuing_ff) begin
         if (issue_row_ff == end_row_ff) begin
            if (!pass_ff && start_ff != range_low) begin
               pass_in      = 1'b1;
               issue_row_in = range_low[PW-1:IW];
               end_row_in   = start_m1[PW-1:IW];
            end else begin
               issuing_in = 1'b0;
            end
         end else begin
            issue_row_in = issue_row_ff + RW'(1);
         end
      end
   end

   assign rd_addr = cmd.rmw_read ? page_ff[PW-1:IW] : issue_row_ff;

   always_comb begin
      use_w   = row_rd_ok_ff ? usable_rd_ff : '0;
      alc_w   = row_rd_ok_ff ? alloc_rd_ff : '0;
      a_bound = ev_pass_ff ? range_low : start_ff;
      b_bound = ev_pass_ff ? {1'b0, start_ff} : hi_eff;
      if (ev_row_ff > a_bound[PW-1:IW]) begin
         lo_mask = '1;
      end else if (ev_row_ff == a_bound[PW-1:IW]) begin
         lo_mask = {WB{1'b1}} << a_bound[IW-1:0];
      end else begin
         lo_mask = '0;
      end
      cand     = use_w & ~alc_w & lo_mask & below_mask(ev_row_ff, b_bound)
                 & below_mask(ev_row_ff, page_count);
      hit_bit  = low_bit(cand);
      hit_page = {ev_row_ff, hit_bit};
      scan_hit = cmd.scan_run && ev_valid_ff && (cand != '0);
      ev_valid_in = cmd.scan_run && issuing_ff && !scan_hit;
      status.ring_empty = ({1'b0, range_low} >= hi_eff);
      status.scan_hit   = scan_hit;
      status.scan_done  = cmd.scan_run && !issuing_ff && !ev_valid_ff;
   end

   always_comb begin
      sel       = WB'(1) << page_ff[IW-1:0];
      wr_en     = scan_hit || cmd.rmw_write;
      wr_addr   = scan_hit ? ev_row_ff : page_ff[PW-1:IW];
      wr_usable = use_w;
      wr_alloc  = alc_w;
      if (scan_hit) begin
         wr_alloc = alc_w | (WB'(1) << hit_bit);
      end else begin
         unique case (op_ff)
            npa_pkg::OP_FREE:          wr_alloc  = alc_w & ~sel;
            npa_pkg::OP_MARK_USABLE:   wr_usable = use_w | sel;
            npa_pkg::OP_MARK_RESERVED: wr_usable = use_w & ~sel;
            default:                   wr_usable = use_w;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      usable_rd_ff <= usable_mem[rd_addr];
      alloc_rd_ff  <= alloc_mem[rd_addr];
      if (wr_en) begin
         usable_mem[wr_addr] <= wr_usable;
         alloc_mem[wr_addr]  <= wr_alloc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ok_ff    <= '0;
         row_rd_ok_ff <= 1'b0;
      end else begin
         row_rd_ok_ff <= row_ok_ff[rd_addr];
         if (wr_en) begin
            row_ok_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_start_ff <= npa_pkg::RANGE_LOW_RESET;
         issuing_ff    <= 1'b0;
         ev_valid_ff   <= 1'b0;
         res_found_ff  <= 1'b0;
      end else begin
         issuing_ff  <= issuing_in;
         ev_valid_ff <= ev_valid_in;
         if (scan_hit) begin
            scan_start_ff <= hit_page;
         end else if (cmd.empty_fail || status.scan_done) begin
            scan_start_ff <= range_low;
         end
         if (cmd.load) begin
            res_found_ff <= 1'b0;
         end else if (scan_hit) begin
            res_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      issue_row_ff <= issue_row_in;
      end_row_ff   <= end_row_in;
      pass_ff      <= pass_in;
      ev_row_ff    <= issue_row_ff;
      ev_pass_ff   <= pass_ff;
      if (cmd.scan_init) begin
         start_ff <= start_eff;
      end
      if (cmd.load) begin
         op_ff       <= req_op;
         page_ff     <= req_page;
         res_page_ff <= '0;
      end else if (scan_hit) begin
         res_page_ff <= hit_page;
      end
   end

   assign granted_page = res_page_ff;
   assign found        = res_found_ff;

endmodule

FILE: design/next_fit_page_allocator_unit.sv
// Channel  Dir  Protocol  Payload
// req      in   stream    tuser: operation; tdata: page_index
// rsp      out  stream    tuser: found; tdata: granted_page
// csr      in   APB       range_low @0x0, range_high @0x4, page_count @0x8
//
// Free and mark read and then write back one 32-page bitmap word; an allocate
// reads the 32-page bitmap words around the ring until it hits or has read
// them all, and an allocate on an empty ring fails without a read. One item
// is in work at a time; a finished result waits in the output register and
// holds the next result back.
// Reset clears the bitmap at once through per-word valid bits, no clearing pass.
module next_fit_page_allocator_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [npa_pkg::REQ_TDATA_W-1:0]  req_tdata,  // [9:0] page_index
   input  logic [npa_pkg::OP_W-1:0]         req_tuser,  // [1:0] operation
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [npa_pkg::RSP_TDATA_W-1:0]  rsp_tdata,  // [9:0] granted_page
   output logic [0:0]                       rsp_tuser,  // [0] found
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [npa_pkg::ADDR_W-1:0]       csr_paddr,
   input  logic [npa_pkg::DATA_W-1:0]       csr_pwdata,
   output logic [npa_pkg::DATA_W-1:0]       csr_prdata,
   output logic                             csr_pready
);

   logic [npa_pkg::PAGE_W-1:0]  range_low_ff;
   logic [npa_pkg::BOUND_W-1:0] range_high_ff;
   logic [npa_pkg::BOUND_W-1:0] page_count_ff;
   logic [1:0]                  reg_index;
   logic                        csr_write;

   npa_pkg::npa_cmd_type    cmd;
   npa_pkg::npa_status_type status;
   logic                        push;
   logic                        out_free;
   logic [npa_pkg::PAGE_W-1:0]  granted_page;
   logic                        found;

   logic                             rsp_valid_ff;
   logic [npa_pkg::RSP_TDATA_W-1:0]  rsp_data_ff;
   logic                             rsp_found_ff;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[npa_pkg::ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= npa_pkg::RANGE_LOW_RESET;
         range_high_ff <= npa_pkg::RANGE_HIGH_RESET;
         page_count_ff <= npa_pkg::PAGE_COUNT_RESET;
      end else if (csr_write) begin
         unique case (reg_index)
            npa_pkg::REG_RANGE_LOW:  range_low_ff  <= csr_pwdata[npa_pkg::PAGE_W-1:0];
            npa_pkg::REG_RANGE_HIGH: range_high_ff <= csr_pwdata[npa_pkg::BOUND_W-1:0];
            npa_pkg::REG_PAGE_COUNT: page_count_ff <= csr_pwdata[npa_pkg::BOUND_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         npa_pkg::REG_RANGE_LOW:  csr_prdata = npa_pkg::DATA_W'(range_low_ff);
         npa_pkg::REG_RANGE_HIGH: csr_prdata = npa_pkg::DATA_W'(range_high_ff);
         npa_pkg::REG_PAGE_COUNT: csr_prdata = npa_pkg::DATA_W'(page_count_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   npa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_op    (req_tuser),
      .out_free  (out_free),
      .status    (status),
      .req_ready (req_tready),
      .push      (push),
      .cmd       (cmd)
   );

   npa_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_op       (req_tuser),
      .req_page     (req_tdata[npa_pkg::PAGE_W-1:0]),
      .range_low    (range_low_ff),
      .range_high   (range_high_ff),
      .page_count   (page_count_ff),
      .granted_page (granted_page),
      .found        (found)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_data_ff  <= npa_pkg::RSP_TDATA_W'(granted_page);
         rsp_found_ff <= found;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_found_ff;

endmodule

FILE: design/npa_checker.sv
`include "next_fit_page_allocator_unit_macros.svh"

module npa_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [npa_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic [0:0]                       rsp_tuser
);

   `NPA_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")
   `NPA_ASSERT(a_miss_zero, rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0, "failed result carries a page")
   `NPA_ASSERT(a_busy_after_take, req_tvalid && req_tready |=> !req_tready, "request taken while busy")
   `NPA_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

bind next_fit_page_allocator_unit npa_checker u_npa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
